[rtl/core/rbee_pkg.sv]
`timescale 1ns / 1ps
package rbee_pkg;

  // Reciprocal 2^32 / d: 33 quotient bits, three restoring steps per stage
  localparam int DIV_STEPS       = 33;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

  localparam logic [31:0] MISS_ENTRY = 32'hFFFF_0000;  // -1.0
  localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN      = 32'h8000_0000;

  localparam int NUM_BOX_REGS = 6;

  localparam logic [2:0] REG_BOX_X_MIN = 3'd0;
  localparam logic [2:0] REG_BOX_X_MAX = 3'd1;
  localparam logic [2:0] REG_BOX_Y_MIN = 3'd2;
  localparam logic [2:0] REG_BOX_Y_MAX = 3'd3;
  localparam logic [2:0] REG_BOX_Z_MIN = 3'd4;
  localparam logic [2:0] REG_BOX_Z_MAX = 3'd5;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] quo;
    logic [31:0] dvs;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic [2:0][32:0] diff_lo;
    logic [2:0][32:0] diff_hi;
    logic [31:0]      near_v;
    logic [31:0]      far_v;
    logic [31:0]      run_v;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] inv;
    side_t            side;
  } recip_t;

  typedef struct packed {
    logic [2:0][31:0] tmin;
    logic [2:0][31:0] tmax;
    logic [31:0]      near_v;
    logic [31:0]      far_v;
    logic [31:0]      run_v;
  } span_t;

  // One restoring division step
  function automatic div_lane_t div_step(div_lane_t l, logic inbit);
    logic [32:0] r2;
    div_lane_t   o;
    r2 = {l.rem, inbit};
    o  = l;
    if (r2 >= {1'b0, l.dvs}) begin
      r2    = r2 - {1'b0, l.dvs};
      o.quo = {l.quo[31:0], 1'b1};
    end else begin
      o.quo = {l.quo[31:0], 1'b0};
    end
    o.rem = r2[31:0];
    return o;
  endfunction

  // Signed quotient with saturation
  function automatic logic [31:0] sign_sat(logic [32:0] q, logic neg);
    logic [31:0] r;
    if (neg) begin
      if (q[32] || (q[31] && (|q[30:0]))) r = Q_MIN;
      else r = 32'd0 - q[31:0];
    end else begin
      if (q[32] || q[31]) r = Q_MAX;
      else r = q[31:0];
    end
    return r;
  endfunction

  // floor(p / 2^16) saturated to 32 bits
  function automatic logic [31:0] sat_prod(logic [64:0] p);
    logic [31:0] r;
    if ((&p[64:47]) || !(|p[64:47])) r = p[47:16];
    else if (p[64]) r = Q_MIN;
    else r = Q_MAX;
    return r;
  endfunction

  function automatic logic [31:0] smin(logic [31:0] a, logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [31:0] smax(logic [31:0] a, logic [31:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

[rtl/core/rbee_recip.sv]
`timescale 1ns / 1ps
module rbee_recip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rbee_pkg::div_lane_t [2:0]    in_lanes,
  input  rbee_pkg::side_t              in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rbee_pkg::recip_t             out_data
);
  import rbee_pkg::*;

  div_lane_t [2:0]        lanes [DIV_STAGES];
  side_t                  side  [DIV_STAGES];
  logic [DIV_STAGES-1:0]  vld;
  logic [DIV_STAGES-1:0]  move;
  logic                   fin_move;

  always_comb begin
    fin_move = !out_valid || out_ready;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      if (s == DIV_STAGES - 1) move[s] = !vld[s] || fin_move;
      else move[s] = !vld[s] || move[s+1];
    end
  end

  assign in_ready = move[0];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_lane_t [2:0] src;
    div_lane_t [2:0] lanes_next;
    side_t           side_src;
    logic            vld_src;

    if (s == 0) begin : g_first
      assign src      = in_lanes;
      assign side_src = in_side;
      assign vld_src  = in_valid;
    end else begin : g_rest
      assign src      = lanes[s-1];
      assign side_src = side[s-1];
      assign vld_src  = vld[s-1];
    end

    always_comb begin
      lanes_next = src;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        for (int a = 0; a < 3; a++) begin
          // the dividend 2^32 has its only set bit at the first step
          lanes_next[a] = div_step(lanes_next[a], (s == 0) && (j == 0));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (move[s]) begin
        vld[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (move[s]) begin
        lanes[s] <= lanes_next;
        side[s]  <= side_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_move) begin
      out_valid <= vld[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      for (int a = 0; a < 3; a++) begin
        out_data.inv[a] <= sign_sat(lanes[DIV_STAGES-1][a].quo, lanes[DIV_STAGES-1][a].neg);
      end
      out_data.side <= side[DIV_STAGES-1];
    end
  end

endmodule

[rtl/core/rbee_slab.sv]
`timescale 1ns / 1ps
module rbee_slab (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbee_pkg::recip_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rbee_pkg::span_t   out_data
);
  import rbee_pkg::*;

  // stage 1: products, stage 2: scaled and saturated, stage 3: per-axis order
  logic [64:0] prod [6];
  logic [31:0] near1, far1, run1;
  logic [31:0] tv [6];
  logic [31:0] near2, far2, run2;
  logic        v1, v2;
  logic        m1, m2, m3;

  assign m3       = !out_valid || out_ready;
  assign m2       = !v2 || m3;
  assign m1       = !v1 || m2;
  assign in_ready = m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m1) v1 <= in_valid;
      if (m2) v2 <= v1;
      if (m3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (m1) begin
      for (int a = 0; a < 3; a++) begin
        prod[2*a]   <= $signed(in_data.side.diff_lo[a]) * $signed(in_data.inv[a]);
        prod[2*a+1] <= $signed(in_data.side.diff_hi[a]) * $signed(in_data.inv[a]);
      end
      near1 <= in_data.side.near_v;
      far1  <= in_data.side.far_v;
      run1  <= in_data.side.run_v;
    end
    if (m2) begin
      for (int i = 0; i < 6; i++) tv[i] <= sat_prod(prod[i]);
      near2 <= near1;
      far2  <= far1;
      run2  <= run1;
    end
    if (m3) begin
      for (int a = 0; a < 3; a++) begin
        out_data.tmin[a] <= smin(tv[2*a], tv[2*a+1]);
        out_data.tmax[a] <= smax(tv[2*a], tv[2*a+1]);
      end
      out_data.near_v <= near2;
      out_data.far_v  <= far2;
      out_data.run_v  <= run2;
    end
  end

endmodule

[rtl/core/ray_box_entry_exit.sv]
`timescale 1ns / 1ps
// Ray against axis-aligned box, slab test, signed Q16.16 throughout.
// Input channel (in_valid / in_ready): one ray per beat - direction, origin,
// near and far limits and a running distance.
// Output channel (out_valid / out_ready): one result per ray, in order -
// entry distance (-1.0 on a miss), running distance, exit distance, miss.
// Box bounds sit in six registers written through cfg_we / cfg_index /
// cfg_data; write them only while no ray is in flight. Out-of-range indexes
// are dropped.
// From accepted input beat to output beat the path runs through an input
// register, eleven divider stages (three quotient bits each) for the three
// reciprocals, a sign/saturate stage, multiply, scale/saturate, per-axis
// ordering, and the output register.
// Throughput: one ray per cycle unless the output stalls; every stage has
// its own valid bit. Reset clears all valid bits and the box registers to
// zero. When the receiver stalls the output beat holds; earlier stages keep
// filling empty slots, so in_ready drops only once the pipe is full.
module ray_box_entry_exit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [31:0] orig_x,
  input  logic [31:0] orig_y,
  input  logic [31:0] orig_z,
  input  logic [31:0] near_limit,
  input  logic [31:0] far_limit,
  input  logic [31:0] run_distance_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] entry_distance,
  output logic [31:0] run_distance_out,
  output logic [31:0] exit_distance,
  output logic        miss
);
  import rbee_pkg::*;

  logic [31:0] box [NUM_BOX_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BOX_REGS; i++) box[i] <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X_MIN: box[0] <= cfg_data;
        REG_BOX_X_MAX: box[1] <= cfg_data;
        REG_BOX_Y_MIN: box[2] <= cfg_data;
        REG_BOX_Y_MAX: box[3] <= cfg_data;
        REG_BOX_Z_MIN: box[4] <= cfg_data;
        REG_BOX_Z_MAX: box[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: divisor magnitude and slab differences
  div_lane_t [2:0] lanes_next;
  div_lane_t [2:0] lanes;
  side_t           side_next;
  side_t           side;
  logic            v0;
  logic            m0;
  logic            rc_ready;
  logic [31:0]     dir_a [3];
  logic [31:0]     org_a [3];

  assign dir_a[0] = dir_x;
  assign dir_a[1] = dir_y;
  assign dir_a[2] = dir_z;
  assign org_a[0] = orig_x;
  assign org_a[1] = orig_y;
  assign org_a[2] = orig_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lanes_next[a].rem = 32'd0;
      lanes_next[a].quo = 33'd0;
      lanes_next[a].neg = dir_a[a][31];
      // zero direction stands in as the smallest positive step
      if (dir_a[a] == 32'd0) lanes_next[a].dvs = 32'd1;
      else if (dir_a[a][31]) lanes_next[a].dvs = 32'd0 - dir_a[a];
      else lanes_next[a].dvs = dir_a[a];
      side_next.diff_lo[a] = {box[2*a][31], box[2*a]} - {org_a[a][31], org_a[a]};
      side_next.diff_hi[a] = {box[2*a+1][31], box[2*a+1]} - {org_a[a][31], org_a[a]};
    end
    side_next.near_v = near_limit;
    side_next.far_v  = far_limit;
    side_next.run_v  = run_distance_in;
  end

  assign m0       = !v0 || rc_ready;
  assign in_ready = m0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (m0) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m0) begin
      lanes <= lanes_next;
      side  <= side_next;
    end
  end

  logic     rc_valid;
  logic     sl_ready;
  recip_t   rc_data;
  logic     sl_valid;
  logic     fin_move;
  span_t    sl_data;

  rbee_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_ready  (rc_ready),
    .in_lanes  (lanes),
    .in_side   (side),
    .out_valid (rc_valid),
    .out_ready (sl_ready),
    .out_data  (rc_data)
  );

  rbee_slab u_slab (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rc_valid),
    .in_ready  (sl_ready),
    .in_data   (rc_data),
    .out_valid (sl_valid),
    .out_ready (fin_move),
    .out_data  (sl_data)
  );

  // output stage
  logic [31:0] entry_v;
  logic [31:0] exit_v;
  logic        miss_v;

  always_comb begin
    entry_v = smax(smax(sl_data.near_v, sl_data.tmin[0]),
                   smax(sl_data.tmin[1], sl_data.tmin[2]));
    exit_v  = smin(smin(sl_data.far_v, sl_data.tmax[0]),
                   smin(sl_data.tmax[1], sl_data.tmax[2]));
    miss_v  = $signed(exit_v) < $signed(entry_v);
  end

  assign fin_move = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_move) begin
      out_valid <= sl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      entry_distance   <= miss_v ? MISS_ENTRY : entry_v;
      run_distance_out <= miss_v ? sl_data.run_v : entry_v;
      exit_distance    <= exit_v;
      miss             <= miss_v;
    end
  end

endmodule

[rtl/core/rbee_checker.sv]
`timescale 1ns / 1ps
module rbee_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] entry_distance,
  input logic [31:0] run_distance_out,
  input logic [31:0] exit_distance,
  input logic        miss
);
  import rbee_pkg::*;

  // nothing leaves the pipe straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_distance)
      && $stable(exit_distance) && $stable(run_distance_out) && $stable(miss))
    else $error("stalled output beat changed");

  a_miss_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && miss |-> entry_distance == MISS_ENTRY)
    else $error("miss without the miss entry value");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !miss |-> run_distance_out == entry_distance
      && $signed(exit_distance) >= $signed(entry_distance))
    else $error("hit with inconsistent distances");

endmodule

bind ray_box_entry_exit rbee_checker u_rbee_checker (.*);
